FILE: hw/rtl/sbci_pkg.sv
// Shared types, codes and constants of the sketch byte command interpreter.
package sbci_pkg;

  localparam int COORD_BITS_DEF = 16;
  localparam int DATA_BITS_DEF  = 32;
  localparam int QUEUE_DEPTH    = 4;

  // Opcodes in the top two bits of a command byte.
  localparam logic [1:0] OP_DX   = 2'd0;
  localparam logic [1:0] OP_DY   = 2'd1;
  localparam logic [1:0] OP_TOOL = 2'd2;
  localparam logic [1:0] OP_DATA = 2'd3;

  // Tool operands.
  localparam logic [5:0] TOP_NONE  = 6'd0;
  localparam logic [5:0] TOP_LINE  = 6'd1;
  localparam logic [5:0] TOP_BLOCK = 6'd2;
  localparam logic [5:0] TOP_COLOR = 6'd3;
  localparam logic [5:0] TOP_LDX   = 6'd4;
  localparam logic [5:0] TOP_LDY   = 6'd5;
  localparam logic [5:0] TOP_SHOW  = 6'd6;
  localparam logic [5:0] TOP_PAUSE = 6'd7;
  localparam logic [5:0] TOP_END   = 6'd8;

  // Pen tools.
  localparam logic [1:0] TOOL_NONE  = 2'd0;
  localparam logic [1:0] TOOL_LINE  = 2'd1;
  localparam logic [1:0] TOOL_BLOCK = 2'd2;

  // Result actions.
  localparam logic [2:0] ACT_LINE  = 3'd0;
  localparam logic [2:0] ACT_BLOCK = 3'd1;
  localparam logic [2:0] ACT_COLOR = 3'd2;
  localparam logic [2:0] ACT_SHOW  = 3'd3;
  localparam logic [2:0] ACT_PAUSE = 3'd4;
  localparam logic [2:0] ACT_END   = 3'd5;

  // Command classes produced by the front end.
  localparam logic [3:0] K_DX    = 4'd0;
  localparam logic [3:0] K_DY    = 4'd1;
  localparam logic [3:0] K_SEL   = 4'd2;
  localparam logic [3:0] K_COLOR = 4'd3;
  localparam logic [3:0] K_LDX   = 4'd4;
  localparam logic [3:0] K_LDY   = 4'd5;
  localparam logic [3:0] K_SHOW  = 4'd6;
  localparam logic [3:0] K_PAUSE = 4'd7;
  localparam logic [3:0] K_END   = 4'd8;
  localparam logic [3:0] K_CLR   = 4'd9;
  localparam logic [3:0] K_DATA  = 4'd10;

  typedef struct packed {
    logic [7:0] cmd_byte;
    logic       new_frame;
  } in_t;

  typedef struct packed {
    logic [2:0]         action;
    logic signed [15:0] from_x;
    logic signed [15:0] from_y;
    logic signed [15:0] to_x;
    logic signed [15:0] to_y;
    logic [31:0]        value;
  } out_t;

  typedef struct packed {
    logic [3:0] kind;
    logic [5:0] operand;
    logic       new_frame;
  } cmd_t;

endpackage

FILE: hw/rtl/sbci_front.sv
// Front end: accepts command bytes and classifies them into queue entries.
module sbci_front (
  input  logic          in_valid,
  output logic          in_ready,
  input  sbci_pkg::in_t in_data,
  input  logic          queue_full,
  output logic          push,
  output sbci_pkg::cmd_t push_cmd
);
  import sbci_pkg::*;

  logic [1:0] opcode;
  logic [5:0] raw;

  assign opcode   = in_data.cmd_byte[7:6];
  assign raw      = in_data.cmd_byte[5:0];
  assign in_ready = !queue_full;
  assign push     = in_valid && !queue_full;

  always_comb begin
    push_cmd.operand   = raw;
    push_cmd.new_frame = in_data.new_frame;
    unique case (opcode)
      OP_DX:   push_cmd.kind = K_DX;
      OP_DY:   push_cmd.kind = K_DY;
      OP_DATA: push_cmd.kind = K_DATA;
      default: begin
        unique case (raw)
          TOP_NONE, TOP_LINE, TOP_BLOCK: push_cmd.kind = K_SEL;
          TOP_COLOR: push_cmd.kind = K_COLOR;
          TOP_LDX:   push_cmd.kind = K_LDX;
          TOP_LDY:   push_cmd.kind = K_LDY;
          TOP_SHOW:  push_cmd.kind = K_SHOW;
          TOP_PAUSE: push_cmd.kind = K_PAUSE;
          TOP_END:   push_cmd.kind = K_END;
          default:   push_cmd.kind = K_CLR;
        endcase
      end
    endcase
  end

endmodule

FILE: hw/rtl/sbci_queue.sv
// Short command queue between the front end and the back end.
module sbci_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  sbci_pkg::cmd_t push_cmd,
  output logic           full,
  input  logic           pop,
  output logic           pop_valid,
  output sbci_pkg::cmd_t pop_cmd
);
  import sbci_pkg::*;

  localparam int AW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  cmd_t          slots_r [QUEUE_DEPTH];
  logic [AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] count_r, count_nxt;

  assign full      = (count_r == CW'(QUEUE_DEPTH));
  assign pop_valid = (count_r != '0);
  assign pop_cmd   = slots_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? AW'(wr_ptr_r + 1'b1) : wr_ptr_r;
    rd_ptr_nxt = pop ? AW'(rd_ptr_r + 1'b1) : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !pop) begin
      count_nxt = CW'(count_r + 1'b1);
    end else if (pop && !push) begin
      count_nxt = CW'(count_r - 1'b1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots_r[wr_ptr_r] <= push_cmd;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !full) else $error("queue written while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> pop_valid) else $error("queue read while empty");
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(QUEUE_DEPTH)) else $error("queue count out of range");

endmodule

FILE: hw/rtl/sbci_back.sv
// Back end: holds the pen state, executes commands and registers results.
module sbci_back #(
  parameter int COORD_BITS = sbci_pkg::COORD_BITS_DEF,
  parameter int DATA_BITS  = sbci_pkg::DATA_BITS_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           cmd_valid,
  input  sbci_pkg::cmd_t cmd,
  output logic           cmd_pop,
  output logic           out_valid,
  input  logic           out_ready,
  output sbci_pkg::out_t out_data
);
  import sbci_pkg::*;

  logic [COORD_BITS-1:0] pen_x_r, pen_x_nxt;
  logic [COORD_BITS-1:0] pen_y_r, pen_y_nxt;
  logic [COORD_BITS-1:0] tgt_x_r, tgt_x_nxt;
  logic [COORD_BITS-1:0] tgt_y_r, tgt_y_nxt;
  logic [1:0]            tool_r, tool_nxt;
  logic [DATA_BITS-1:0]  acc_r, acc_nxt;
  logic                  fin_r, fin_nxt;
  logic                  out_valid_r;
  out_t                  out_data_r;

  logic                  back_ready;
  logic                  emit;
  out_t                  res;

  assign back_ready = !out_valid_r || out_ready;
  assign cmd_pop    = cmd_valid && back_ready;
  assign out_valid  = out_valid_r;
  assign out_data   = out_data_r;

  always_comb begin
    logic [COORD_BITS-1:0] px, py, tx, ty, addend, ty_new;
    logic signed [COORD_BITS-1:0] s_fx, s_fy, s_tx, s_ty;
    logic [1:0]            tl;
    logic [DATA_BITS-1:0]  acc;
    logic                  fin;

    // A new frame puts everything back to its reset values before the byte.
    px  = cmd.new_frame ? '0 : pen_x_r;
    py  = cmd.new_frame ? '0 : pen_y_r;
    tx  = cmd.new_frame ? '0 : tgt_x_r;
    ty  = cmd.new_frame ? '0 : tgt_y_r;
    tl  = cmd.new_frame ? TOOL_LINE : tool_r;
    acc = cmd.new_frame ? '0 : acc_r;
    fin = cmd.new_frame ? 1'b0 : fin_r;

    addend = {{(COORD_BITS-6){cmd.operand[5]}}, cmd.operand};
    ty_new = COORD_BITS'(ty + addend);
    s_fx   = '0;
    s_fy   = '0;
    s_tx   = '0;
    s_ty   = '0;

    pen_x_nxt = px;
    pen_y_nxt = py;
    tgt_x_nxt = tx;
    tgt_y_nxt = ty;
    tool_nxt  = tl;
    acc_nxt   = acc;
    fin_nxt   = fin;
    emit      = 1'b0;
    res       = '0;

    if (!fin) begin
      unique case (cmd.kind)
        K_DX: tgt_x_nxt = COORD_BITS'(tx + addend);
        K_DY: begin
          tgt_y_nxt = ty_new;
          pen_x_nxt = tx;
          pen_y_nxt = ty_new;
          s_fx      = px;
          s_fy      = py;
          if (tl == TOOL_LINE) begin
            emit       = 1'b1;
            res.action = ACT_LINE;
            s_tx       = tx;
            s_ty       = ty_new;
          end else if (tl == TOOL_BLOCK) begin
            emit       = 1'b1;
            res.action = ACT_BLOCK;
            s_tx       = COORD_BITS'(tx - px);
            s_ty       = COORD_BITS'(ty_new - py);
          end
          res.from_x = 16'(s_fx);
          res.from_y = 16'(s_fy);
          res.to_x   = 16'(s_tx);
          res.to_y   = 16'(s_ty);
          if (!emit) begin
            res = '0;
          end
        end
        K_SEL: begin
          tool_nxt = cmd.operand[1:0];
          acc_nxt  = '0;
        end
        K_COLOR: begin
          emit       = 1'b1;
          res.action = ACT_COLOR;
          res.value  = 32'(acc);
          acc_nxt    = '0;
        end
        K_LDX: begin
          tgt_x_nxt = COORD_BITS'(acc);
          acc_nxt   = '0;
        end
        K_LDY: begin
          tgt_y_nxt = COORD_BITS'(acc);
          acc_nxt   = '0;
        end
        K_SHOW: begin
          emit       = 1'b1;
          res.action = ACT_SHOW;
          acc_nxt    = '0;
        end
        K_PAUSE: begin
          emit       = 1'b1;
          res.action = ACT_PAUSE;
          res.value  = 32'(acc);
          acc_nxt    = '0;
        end
        K_END: begin
          emit       = 1'b1;
          res.action = ACT_END;
          fin_nxt    = 1'b1;
          acc_nxt    = '0;
        end
        K_DATA: acc_nxt = DATA_BITS'({acc, cmd.operand});
        default: acc_nxt = '0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pen_x_r     <= '0;
      pen_y_r     <= '0;
      tgt_x_r     <= '0;
      tgt_y_r     <= '0;
      tool_r      <= TOOL_LINE;
      acc_r       <= '0;
      fin_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd_pop) begin
        pen_x_r <= pen_x_nxt;
        pen_y_r <= pen_y_nxt;
        tgt_x_r <= tgt_x_nxt;
        tgt_y_r <= tgt_y_nxt;
        tool_r  <= tool_nxt;
        acc_r   <= acc_nxt;
        fin_r   <= fin_nxt;
      end
      if (back_ready) begin
        out_valid_r <= cmd_pop && emit;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_pop && emit) begin
      out_data_r <= res;
    end
  end

  a_tool_legal: assert property (@(posedge clk) disable iff (!rst_n)
    tool_r != 2'd3) else $error("illegal pen tool");
  a_silent_after_end: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_pop && fin_r && !cmd.new_frame |=> !out_valid_r)
    else $error("result after end of stream");
  a_end_sets_fin: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_pop && emit && res.action == ACT_END |=> fin_r)
    else $error("end did not stop the stream");

endmodule

FILE: hw/rtl/sketch_byte_command_interpreter.sv
// Top level of the sketch byte command interpreter.
// Takes one command byte per beat and returns at most one drawing or control
// result for it. A byte is accepted every cycle while the four-entry command
// queue has room; the back end retires one queued command per cycle whenever
// its output register is empty or being taken, so the sustained rate is one
// byte per cycle while results are taken, and each result is registered.
// Bytes after an end command give no result until a byte with new_frame set.
module sketch_byte_command_interpreter #(
  parameter int COORD_BITS = sbci_pkg::COORD_BITS_DEF,
  parameter int DATA_BITS  = sbci_pkg::DATA_BITS_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  sbci_pkg::in_t  in_data,
  output logic           out_valid,
  input  logic           out_ready,
  output sbci_pkg::out_t out_data
);
  import sbci_pkg::*;

  logic queue_full;
  logic push;
  cmd_t push_cmd;
  logic pop;
  logic pop_valid;
  cmd_t pop_cmd;

  sbci_front u_front (
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .queue_full (queue_full),
    .push       (push),
    .push_cmd   (push_cmd)
  );

  sbci_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_cmd  (push_cmd),
    .full      (queue_full),
    .pop       (pop),
    .pop_valid (pop_valid),
    .pop_cmd   (pop_cmd)
  );

  sbci_back #(
    .COORD_BITS (COORD_BITS),
    .DATA_BITS  (DATA_BITS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (pop_valid),
    .cmd       (pop_cmd),
    .cmd_pop   (pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

FILE: dv/sbci_command_checker.sv
// Checker that predicts and compares the results of the sketch byte command interpreter.
module sbci_command_checker (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  input  logic           in_ready,
  input  sbci_pkg::in_t  in_data,
  input  logic           out_valid,
  input  logic           out_ready,
  input  sbci_pkg::out_t out_data,
  output int             mismatch_count,
  output int             results_due
);
  import sbci_pkg::*;

  logic [15:0] pen_x;
  logic [15:0] pen_y;
  logic [15:0] tgt_x;
  logic [15:0] tgt_y;
  logic [1:0]  tool;
  logic [31:0] accum;
  logic        ended;
  out_t        due_q[$];
  int          errors = 0;

  task automatic clear_pen_state();
    pen_x = '0;
    pen_y = '0;
    tgt_x = '0;
    tgt_y = '0;
    tool  = TOOL_LINE;
    accum = '0;
    ended = 1'b0;
  endtask

  // Applies one command byte to the shadow state and queues the result it draws.
  task automatic interpret_byte(input in_t beat);
    logic [1:0]  opcode;
    logic [5:0]  operand;
    logic [15:0] addend;
    out_t        res;
    bit          emit;
    opcode  = beat.cmd_byte[7:6];
    operand = beat.cmd_byte[5:0];
    addend  = {{10{operand[5]}}, operand};
    res     = '0;
    emit    = 1'b0;
    if (beat.new_frame) clear_pen_state();
    if (ended) return;
    case (opcode)
      OP_DX: tgt_x = tgt_x + addend;
      OP_DY: begin
        tgt_y = tgt_y + addend;
        if (tool == TOOL_LINE) begin
          res.action = ACT_LINE;
          res.from_x = pen_x;
          res.from_y = pen_y;
          res.to_x   = tgt_x;
          res.to_y   = tgt_y;
          emit       = 1'b1;
        end else if (tool == TOOL_BLOCK) begin
          res.action = ACT_BLOCK;
          res.from_x = pen_x;
          res.from_y = pen_y;
          res.to_x   = tgt_x - pen_x;
          res.to_y   = tgt_y - pen_y;
          emit       = 1'b1;
        end
        // The pen follows the target even when no tool is selected.
        pen_x = tgt_x;
        pen_y = tgt_y;
      end
      OP_TOOL: begin
        case (operand)
          TOP_NONE:  tool = TOOL_NONE;
          TOP_LINE:  tool = TOOL_LINE;
          TOP_BLOCK: tool = TOOL_BLOCK;
          TOP_COLOR: begin
            res.action = ACT_COLOR;
            res.value  = accum;
            emit       = 1'b1;
          end
          TOP_LDX:   tgt_x = accum[15:0];
          TOP_LDY:   tgt_y = accum[15:0];
          TOP_SHOW: begin
            res.action = ACT_SHOW;
            emit       = 1'b1;
          end
          TOP_PAUSE: begin
            res.action = ACT_PAUSE;
            res.value  = accum;
            emit       = 1'b1;
          end
          TOP_END: begin
            res.action = ACT_END;
            ended      = 1'b1;
            emit       = 1'b1;
          end
          default: ;
        endcase
        accum = '0;
      end
      default: accum = (accum << 6) + {26'b0, operand};
    endcase
    if (emit) due_q.push_back(res);
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      errors++;
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin : track
    out_t want;
    if (!rst_n) begin
      clear_pen_state();
      due_q.delete();
    end else begin
      if (in_valid && in_ready) interpret_byte(in_data);
      if (out_valid && out_ready) begin
        if (due_q.size() == 0) begin
          errors++;
          $display("%0t: unexpected result, expected none, actual %p", $time, out_data);
        end else begin
          want = due_q.pop_front();
          check_field("action", want.action, out_data.action);
          check_field("from_x", want.from_x, out_data.from_x);
          check_field("from_y", want.from_y, out_data.from_y);
          check_field("to_x", want.to_x, out_data.to_x);
          check_field("to_y", want.to_y, out_data.to_y);
          check_field("value", want.value, out_data.value);
        end
      end
    end
    results_due    <= due_q.size();
    mismatch_count <= errors;
  end

endmodule

FILE: dv/sketch_byte_command_interpreter_tb.sv
// Testbench top that drives command bytes into the interpreter and gives the verdict.
module sketch_byte_command_interpreter_tb;
  import sbci_pkg::*;

  localparam int STALL_LIMIT     = 5000;
  localparam int DRAIN_CYCLES    = 20;
  localparam int ITEMS_PER_PHASE = 175;

  logic clk       = 1'b0;
  logic rst_n     = 1'b0;
  logic in_valid  = 1'b0;
  logic in_ready;
  in_t  in_data   = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_t out_data;

  int mismatch_count;
  int results_due;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int quiet_cycles  = 0;
  bit frame_ended   = 1'b0;

  sketch_byte_command_interpreter u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  sbci_command_checker u_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_data        (in_data),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_data       (out_data),
    .mismatch_count (mismatch_count),
    .results_due    (results_due)
  );

  always #1 clk = ~clk;

  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Ends the run if the block stops taking or giving beats.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // Offers one beat and returns once it is taken. handled tells whether the
  // block acts on the byte rather than ignoring it after an end command.
  task automatic send_beat(input in_t beat, output bit handled);
    handled = beat.new_frame || !frame_ended;
    if (beat.new_frame) frame_ended = 1'b0;
    if (!frame_ended && beat.cmd_byte == {OP_TOOL, TOP_END}) frame_ended = 1'b1;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= beat;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic send_cmd(input logic [1:0] op, input logic [5:0] operand,
                          input logic new_frame);
    in_t beat;
    bit  handled;
    beat.cmd_byte  = {op, operand};
    beat.new_frame = new_frame;
    send_beat(beat, handled);
  endtask

  // Mostly drawing and data bytes, with a rare end; a new frame usually follows an end.
  function automatic in_t random_beat(input bit after_end);
    in_t beat;
    int  pick;
    pick           = $urandom_range(99);
    beat.new_frame = (after_end && $urandom_range(9) < 7) || ($urandom_range(99) < 3);
    if (pick < 25)      beat.cmd_byte = {OP_DX, 6'($urandom)};
    else if (pick < 50) beat.cmd_byte = {OP_DY, 6'($urandom)};
    else if (pick < 68) beat.cmd_byte = {OP_DATA, 6'($urandom)};
    else if (pick < 96) beat.cmd_byte = {OP_TOOL, 6'($urandom_range(7))};
    else if (pick < 98) beat.cmd_byte = {OP_TOOL, 6'($urandom_range(63, 9))};
    else                beat.cmd_byte = {OP_TOOL, TOP_END};
    return beat;
  endfunction

  initial begin
    int live_items;
    bit handled;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    send_idle_pct = 27;
    recv_idle_pct = 57;

    // Largest moves both ways, then a block with negative width.
    send_cmd(OP_DX, 6'd31, 1'b1);
    send_cmd(OP_DY, 6'h20, 1'b0);
    send_cmd(OP_TOOL, TOP_BLOCK, 1'b0);
    send_cmd(OP_DX, 6'h3f, 1'b0);
    send_cmd(OP_DY, 6'h01, 1'b0);
    // Overflow the accumulator and read it back as a colour.
    repeat (6) send_cmd(OP_DATA, 6'h3f, 1'b0);
    send_cmd(OP_TOOL, TOP_COLOR, 1'b0);
    // Load a target from an accumulator wider than a coordinate.
    repeat (3) send_cmd(OP_DATA, 6'h3f, 1'b0);
    send_cmd(OP_TOOL, TOP_LDX, 1'b0);
    send_cmd(OP_DATA, 6'd5, 1'b0);
    send_cmd(OP_TOOL, TOP_LDY, 1'b0);
    send_cmd(OP_DATA, 6'd9, 1'b0);
    send_cmd(OP_TOOL, TOP_PAUSE, 1'b0);
    // No tool: the pen moves without drawing.
    send_cmd(OP_TOOL, TOP_NONE, 1'b0);
    send_cmd(OP_DY, 6'd0, 1'b0);
    send_cmd(OP_TOOL, 6'd9, 1'b0);
    send_cmd(OP_TOOL, 6'h3f, 1'b0);
    send_cmd(OP_TOOL, TOP_SHOW, 1'b0);
    // After an end the next byte is dropped until a new frame starts.
    send_cmd(OP_TOOL, TOP_END, 1'b0);
    send_cmd(OP_DY, 6'd5, 1'b0);
    send_cmd(OP_DY, 6'd5, 1'b1);

    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          send_idle_pct = 27;
          recv_idle_pct = 57;
        end
        1: begin
          send_idle_pct = 57;
          recv_idle_pct = 27;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      live_items = 0;
      while (live_items < ITEMS_PER_PHASE) begin
        send_beat(random_beat(frame_ended), handled);
        if (handled) live_items++;
      end
    end

    in_valid <= 1'b0;
    while (results_due != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && results_due == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

FILE: sketch_byte_command_interpreter.f
hw/rtl/sbci_pkg.sv
hw/rtl/sbci_front.sv
hw/rtl/sbci_queue.sv
hw/rtl/sbci_back.sv
hw/rtl/sketch_byte_command_interpreter.sv
dv/sbci_command_checker.sv
dv/sketch_byte_command_interpreter_tb.sv
